// ----- rtl/mcc_pkg.sv -----
package mcc_pkg;

  localparam int MaxChannels = 16;
  localparam int MaxDim      = 32;
  localparam int MaxKernel   = 5;
  localparam int MaxFilters  = 16;

  localparam int InDepth = MaxChannels * MaxDim * MaxDim;
  localparam int WDepth  = MaxFilters * MaxChannels * MaxKernel * MaxKernel;
  localparam int BDepth  = MaxFilters;

  localparam int InAw = $clog2(InDepth);
  localparam int WAw  = $clog2(WDepth);
  localparam int BAw  = $clog2(BDepth);

  localparam int ChW = $clog2(MaxChannels + 1);
  localparam int DimW = $clog2(MaxDim + 1);
  localparam int KW  = $clog2(MaxKernel + 1);
  localparam int FW  = $clog2(MaxFilters + 1);

  localparam int AccW = 48;

  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OpPixel  = 2'd0,
    OpWeight = 2'd1,
    OpBias   = 2'd2,
    OpConv   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegInCh  = 3'd0,
    RegInH   = 3'd1,
    RegInW   = 3'd2,
    RegKh    = 3'd3,
    RegKw    = 3'd4,
    RegOutCh = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRun  = 2'd1,
    StBias = 2'd2,
    StDone = 2'd3
  } bk_state_e;

  typedef struct packed {
    logic [4:0] in_channels;
    logic [5:0] in_height;
    logic [5:0] in_width;
    logic [2:0] kernel_height;
    logic [2:0] kernel_width;
    logic [4:0] out_channels;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [13:0] addr;
    logic [31:0] value;
    logic [3:0]  oc;
    logic [4:0]  orow;
    logic [4:0]  ocol;
    logic        bad;
    logic [ChW-1:0] nc;
    logic [KW-1:0]  kh;
    logic [KW-1:0]  kw;
  } cmd_t;

  function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) r = 32'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/mcc_if.sv -----
interface mcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [13:0] load_address;
  logic signed [31:0] load_value;
  logic [3:0]  out_channel;
  logic [4:0]  out_row;
  logic [4:0]  out_col;
  modport source (output valid, opcode, load_address, load_value, out_channel, out_row,
                  out_col, input ready);
  modport sink (input valid, opcode, load_address, load_value, out_channel, out_row,
                out_col, output ready);
endinterface

interface mcc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_value;
  logic        saturated;
  logic        bad_position;
  modport source (output valid, out_value, saturated, bad_position, input ready);
  modport sink (input valid, out_value, saturated, bad_position, output ready);
endinterface

// ----- rtl/mcc_front.sv -----
module mcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcc_in_if.sink            in_if,
  input  mcc_pkg::cfg_t     cfg_i,
  output logic              cmd_valid_o,
  output mcc_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  mcc_pkg::cmd_t cmd_w;
  mcc_pkg::cmd_t q_q [mcc_pkg::QDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push;
  logic [31:0] nc, ih, iw, kh, kw, nf;

  always_comb begin
    nc = mcc_pkg::clamp_reg({27'd0, cfg_i.in_channels}, 32'(mcc_pkg::MaxChannels));
    ih = mcc_pkg::clamp_reg({26'd0, cfg_i.in_height}, 32'(mcc_pkg::MaxDim));
    iw = mcc_pkg::clamp_reg({26'd0, cfg_i.in_width}, 32'(mcc_pkg::MaxDim));
    kh = mcc_pkg::clamp_reg({29'd0, cfg_i.kernel_height}, 32'(mcc_pkg::MaxKernel));
    kw = mcc_pkg::clamp_reg({29'd0, cfg_i.kernel_width}, 32'(mcc_pkg::MaxKernel));
    nf = mcc_pkg::clamp_reg({27'd0, cfg_i.out_channels}, 32'(mcc_pkg::MaxFilters));
    cmd_w.op    = mcc_pkg::op_e'(in_if.opcode);
    cmd_w.addr  = in_if.load_address;
    cmd_w.value = in_if.load_value;
    cmd_w.oc    = in_if.out_channel;
    cmd_w.orow  = in_if.out_row;
    cmd_w.ocol  = in_if.out_col;
    cmd_w.nc    = nc[mcc_pkg::ChW-1:0];
    cmd_w.kh    = kh[mcc_pkg::KW-1:0];
    cmd_w.kw    = kw[mcc_pkg::KW-1:0];
    cmd_w.bad   = (kh > ih) || (kw > iw) || ({28'd0, in_if.out_channel} >= nf);
    if (!cmd_w.bad && (({27'd0, in_if.out_row} > ih - kh) ||
                       ({27'd0, in_if.out_col} > iw - kw))) begin
      cmd_w.bad = 1'b1;
    end
  end

  assign in_if.ready = (cnt_q != 2'(mcc_pkg::QDepth));
  assign push = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= cmd_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(mcc_pkg::QDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop of empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(mcc_pkg::QDepth) |-> !in_if.ready) else $error("ready while full");

endmodule

// ----- rtl/mcc_back.sv -----
module mcc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  mcc_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  mcc_out_if.source         out_if
);

  logic [15:0] in_mem [mcc_pkg::InDepth];
  logic [15:0] w_mem  [mcc_pkg::WDepth];
  logic [31:0] b_mem  [mcc_pkg::BDepth];

  mcc_pkg::bk_state_e state_q, state_d;
  logic [mcc_pkg::ChW-1:0] c_q, c_d;
  logic [mcc_pkg::KW-1:0]  p_q, p_d, q_q, q_d;
  logic issue_q, issue_d;
  logic [15:0] x_q, w_q;
  logic [31:0] b_q;
  logic signed [31:0] prod_q;
  logic prod_v_q;
  logic signed [mcc_pkg::AccW-1:0] acc_q;
  logic [mcc_pkg::InAw-1:0] xa;
  logic [mcc_pkg::WAw-1:0]  wa;
  logic last;
  logic out_v_q;
  logic signed [31:0] out_val_q;
  logic out_sat_q, out_bad_q;
  logic is_load;
  logic drain_q, drain_d;

  assign is_load = cmd_valid_i && (cmd_i.op != mcc_pkg::OpConv);

  always_comb begin
    xa = mcc_pkg::InAw'((32'(c_q) * 32'(mcc_pkg::MaxDim) + 32'(cmd_i.orow) + 32'(p_q))
         * 32'(mcc_pkg::MaxDim) + 32'(cmd_i.ocol) + 32'(q_q));
    wa = mcc_pkg::WAw'(((32'(cmd_i.oc) * 32'(mcc_pkg::MaxChannels) + 32'(c_q))
         * 32'(mcc_pkg::MaxKernel) + 32'(p_q)) * 32'(mcc_pkg::MaxKernel) + 32'(q_q));
  end

  // Store writes from load words
  always_ff @(posedge clk_i) begin
    if (is_load && state_q == mcc_pkg::StIdle) begin
      unique case (cmd_i.op)
        mcc_pkg::OpPixel:
          if (32'(cmd_i.addr) < 32'(mcc_pkg::InDepth))
            in_mem[mcc_pkg::InAw'(cmd_i.addr)] <= cmd_i.value[15:0];
        mcc_pkg::OpWeight:
          if (32'(cmd_i.addr) < 32'(mcc_pkg::WDepth))
            w_mem[mcc_pkg::WAw'(cmd_i.addr)] <= cmd_i.value[15:0];
        mcc_pkg::OpBias:
          if (32'(cmd_i.addr) < 32'(mcc_pkg::BDepth))
            b_mem[mcc_pkg::BAw'(cmd_i.addr)] <= cmd_i.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= in_mem[xa];
    w_q <= w_mem[wa];
    b_q <= b_mem[cmd_i.oc];
    prod_q <= $signed(x_q) * $signed(w_q);
  end

  assign last = (c_q == cmd_i.nc - 1'b1) && (p_q == cmd_i.kh - 1'b1) && (q_q == cmd_i.kw - 1'b1);

  always_comb begin
    state_d = state_q;
    c_d = c_q;
    p_d = p_q;
    q_d = q_q;
    issue_d = 1'b0;
    drain_d = 1'b0;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      mcc_pkg::StIdle: begin
        if (cmd_valid_i) begin
          if (is_load) begin
            cmd_pop_o = 1'b1;
          end else if (!out_v_q) begin
            if (cmd_i.bad) begin
              state_d = mcc_pkg::StDone;
            end else begin
              state_d = mcc_pkg::StRun;
              c_d = '0;
              p_d = '0;
              q_d = '0;
            end
          end
        end
      end
      mcc_pkg::StRun: begin
        issue_d = 1'b1;
        if (last) begin
          state_d = mcc_pkg::StBias;
        end else if (q_q == cmd_i.kw - 1'b1) begin
          q_d = '0;
          if (p_q == cmd_i.kh - 1'b1) begin
            p_d = '0;
            c_d = c_q + 1'b1;
          end else begin
            p_d = p_q + 1'b1;
          end
        end else begin
          q_d = q_q + 1'b1;
        end
      end
      mcc_pkg::StBias: begin
        // wait for the multiply pipe to empty
        drain_d = 1'b1;
        if (drain_q && !issue_q && !prod_v_q) state_d = mcc_pkg::StDone;
      end
      mcc_pkg::StDone: begin
        cmd_pop_o = 1'b1;
        state_d = mcc_pkg::StIdle;
      end
      default: state_d = mcc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcc_pkg::StIdle;
      c_q <= '0;
      p_q <= '0;
      q_q <= '0;
      issue_q <= 1'b0;
      prod_v_q <= 1'b0;
      drain_q <= 1'b0;
      acc_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q <= c_d;
      p_q <= p_d;
      q_q <= q_d;
      issue_q <= issue_d;
      prod_v_q <= issue_q;
      drain_q <= drain_d;
      if (state_q == mcc_pkg::StIdle) acc_q <= '0;
      else if (prod_v_q) acc_q <= acc_q + mcc_pkg::AccW'(prod_q);
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      if (state_q == mcc_pkg::StDone) out_v_q <= 1'b1;
    end
  end

  logic signed [mcc_pkg::AccW-1:0] tot;
  assign tot = acc_q + mcc_pkg::AccW'($signed(b_q));

  always_ff @(posedge clk_i) begin
    if (state_q == mcc_pkg::StDone) begin
      if (cmd_i.bad) begin
        out_val_q <= '0;
        out_sat_q <= 1'b0;
        out_bad_q <= 1'b1;
      end else if (tot > mcc_pkg::AccW'(33'sh0_7FFF_FFFF)) begin
        out_val_q <= 32'sh7FFF_FFFF;
        out_sat_q <= 1'b1;
        out_bad_q <= 1'b0;
      end else if (tot < -mcc_pkg::AccW'(33'sh0_8000_0000)) begin
        out_val_q <= 32'sh8000_0000;
        out_sat_q <= 1'b1;
        out_bad_q <= 1'b0;
      end else begin
        out_val_q <= tot[31:0];
        out_sat_q <= 1'b0;
        out_bad_q <= 1'b0;
      end
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.out_value = out_val_q;
  assign out_if.saturated = out_sat_q;
  assign out_if.bad_position = out_bad_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcc_pkg::StDone |-> !out_v_q) else $error("result overwritten");
  a_pop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == mcc_pkg::OpConv) |-> state_q == mcc_pkg::StDone)
    else $error("compute popped early");
  a_run_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcc_pkg::StRun |-> cmd_valid_i) else $error("run without command");

endmodule

// ----- rtl/multichannel_conv2d_unit.sv -----
// Load words are written to their store as the idle back end takes them from the queue.
// A compute word runs on the single multiply-accumulate unit, reading one pixel and one
// weight per cycle for in_channels*kernel_height*kernel_width products, then the bias
// is added; an out-of-bounds position skips the products and answers with bad_position.
// Up to two words queue ahead, so loads stream while a result waits to be taken.
// rst_ni clears control and the registers to their defaults; stores hold no reset.
module multichannel_conv2d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcc_in_if.sink      in_if,
  mcc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mcc_pkg::cfg_t cfg_q;
  mcc_pkg::cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{in_channels: 5'd1, in_height: 6'd32, in_width: 6'd32,
                 kernel_height: 3'd3, kernel_width: 3'd3, out_channels: 5'd1};
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        mcc_pkg::RegInCh:  cfg_q.in_channels <= pwdata[4:0];
        mcc_pkg::RegInH:   cfg_q.in_height <= pwdata[5:0];
        mcc_pkg::RegInW:   cfg_q.in_width <= pwdata[5:0];
        mcc_pkg::RegKh:    cfg_q.kernel_height <= pwdata[2:0];
        mcc_pkg::RegKw:    cfg_q.kernel_width <= pwdata[2:0];
        mcc_pkg::RegOutCh: cfg_q.out_channels <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      mcc_pkg::RegInCh:  prdata = {27'd0, cfg_q.in_channels};
      mcc_pkg::RegInH:   prdata = {26'd0, cfg_q.in_height};
      mcc_pkg::RegInW:   prdata = {26'd0, cfg_q.in_width};
      mcc_pkg::RegKh:    prdata = {29'd0, cfg_q.kernel_height};
      mcc_pkg::RegKw:    prdata = {29'd0, cfg_q.kernel_width};
      mcc_pkg::RegOutCh: prdata = {27'd0, cfg_q.out_channels};
      default:           prdata = '0;
    endcase
  end

  mcc_front u_front (
    .clk_i, .rst_ni, .in_if, .cfg_i(cfg_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  mcc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .out_if
  );

endmodule
